### hdl/rsd_pkg.sv
// rsd_pkg: shared types and constants for the ROI shift dequantizer.
// Used by every module in hdl/; depends on nothing.
`timescale 1ns / 1ps

package rsd_pkg;

  localparam int unsigned COEF_W  = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROI_SHIFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_SHIFT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BITPLANES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd4;

  // reset values
  localparam logic [SHIFT_W-1:0] RST_ROI_SHIFT     = 5'd0;
  localparam logic [SHIFT_W-1:0] RST_BG_SHIFT      = 5'd0;
  localparam logic [SHIFT_W-1:0] RST_NUM_BITPLANES = 5'd31;
  localparam logic               RST_REAL_MODE     = 1'b0;
  localparam logic [STEP_W-1:0]  RST_STEP_SIZE     = 31'd8192;

  typedef struct packed {
    logic [SHIFT_W-1:0] roi_shift;
    logic [SHIFT_W-1:0] bg_shift;
    logic [SHIFT_W-1:0] num_bitplanes;
    logic               real_mode;
    logic [STEP_W-1:0]  step_size;
  } cfg_t;

  typedef struct packed {
    logic [COEF_W-1:0] data;
    logic              trimmed;
  } roi_res_t;

endpackage

### hdl/rsd_cfg.sv
// rsd_cfg: configuration register file with a plain write port.
// Depends on rsd_pkg.
`timescale 1ns / 1ps

module rsd_cfg import rsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  index,
  input  logic [CFG_DATA_W-1:0] wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      unique case (index)
        REG_ROI_SHIFT:     cfg_nxt.roi_shift     = wdata[SHIFT_W-1:0];
        REG_BG_SHIFT:      cfg_nxt.bg_shift      = wdata[SHIFT_W-1:0];
        REG_NUM_BITPLANES: cfg_nxt.num_bitplanes = wdata[SHIFT_W-1:0];
        REG_REAL_MODE:     cfg_nxt.real_mode     = wdata[0];
        REG_STEP_SIZE:     cfg_nxt.step_size     = wdata[STEP_W-1:0];
        default:           cfg_nxt = cfg_r;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.roi_shift     <= RST_ROI_SHIFT;
      cfg_r.bg_shift      <= RST_BG_SHIFT;
      cfg_r.num_bitplanes <= RST_NUM_BITPLANES;
      cfg_r.real_mode     <= RST_REAL_MODE;
      cfg_r.step_size     <= RST_STEP_SIZE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/rsd_roi.sv
// rsd_roi: max-shift ROI descaling of one coefficient (combinational).
// Depends on rsd_pkg.
`timescale 1ns / 1ps

module rsd_roi import rsd_pkg::*; (
  input  logic [COEF_W-1:0] coefficient,
  input  cfg_t              cfg,
  output roi_res_t          res
);

  logic                  neg;
  logic                  active;
  logic                  roi_hit;
  logic [COEF_W-1:0]     mag;
  logic [COEF_W-1:0]     roi_mag;
  logic [COEF_W-1:0]     bg_mask;
  logic [COEF_W-1:0]     mag_out;
  logic [2*COEF_W-2:0]   wide;
  logic [2*COEF_W-2:0]   above;

  always_comb begin
    neg     = coefficient[COEF_W-1];
    active  = (cfg.roi_shift != '0) || (cfg.bg_shift != '0);
    mag     = neg ? (~coefficient + 32'd1) : coefficient;
    roi_mag = mag >> cfg.roi_shift;
    // mag >= 2^roi_shift exactly when something survives the right shift
    roi_hit = (roi_mag != '0);
    wide    = {{(COEF_W-1){1'b0}}, mag} << cfg.bg_shift;
    above   = wide >> cfg.num_bitplanes;
    bg_mask = (32'd1 << cfg.num_bitplanes) - 32'd1;

    if (roi_hit) begin
      mag_out = roi_mag;
    end else begin
      mag_out = wide[COEF_W-1:0] & bg_mask;
    end

    if (active) begin
      res.data    = neg ? (~mag_out + 32'd1) : mag_out;
      res.trimmed = !roi_hit && (above != '0);
    end else begin
      res.data    = coefficient;
      res.trimmed = 1'b0;
    end
  end

endmodule

### hdl/rsd_scale.sv
// rsd_scale: fixed-point step-size scaling in real mode (combinational).
// Depends on rsd_pkg.
`timescale 1ns / 1ps

module rsd_scale import rsd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 13
) (
  input  logic [COEF_W-1:0] data,
  input  logic              real_mode,
  input  logic [STEP_W-1:0] step_size,
  output logic [COEF_W-1:0] result
);

  logic [COEF_W-1:0]            fx;
  logic signed [COEF_W+STEP_W-1:0] prod;

  always_comb begin
    fx   = data << FRAC_BITS;
    // exact signed product: 32-bit signed times 31-bit unsigned fits 63 bits
    prod = $signed(fx) * $signed({1'b0, step_size});
    if (real_mode) begin
      result = prod[FRAC_BITS +: COEF_W];
    end else begin
      result = data;
    end
  end

endmodule

### hdl/roi_shift_dequantizer_top.sv
// roi_shift_dequantizer_top: ROI descaling plus fixed-point dequantization.
// Depends on rsd_pkg, rsd_cfg, rsd_roi and rsd_scale.
`timescale 1ns / 1ps

// Takes one signed coefficient per transfer and returns one dequantized sample
// and a trim flag per transfer. Sustained rate is one item per clock unless
// out_ready is low; an item is registered in stage one, then in the output
// register. ROI shifting, background masking and sign restore run before the
// first register stage; the single 32x31 multiply for real mode runs between
// that stage and the output register. Configuration is written through
// cfg_we/cfg_index/cfg_wdata and must only change while no item is in flight.
module roi_shift_dequantizer_top import rsd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COEF_W-1:0]     in_coefficient,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COEF_W-1:0]     out_sample_out,
  output logic                  out_bits_trimmed,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t              cfg;
  roi_res_t          roi_res;
  logic [COEF_W-1:0] scaled;

  logic              v1_r, v1_nxt;
  roi_res_t          s1_r;
  logic              v2_r, v2_nxt;
  logic [COEF_W-1:0] samp_r;
  logic              trim_r;
  logic              adv2;

  rsd_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  rsd_roi u_roi (
    .coefficient (in_coefficient),
    .cfg         (cfg),
    .res         (roi_res)
  );

  rsd_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .data      (s1_r.data),
    .real_mode (cfg.real_mode),
    .step_size (cfg.step_size),
    .result    (scaled)
  );

  // elastic two-stage pipe: each stage loads when it is empty or drains
  assign adv2     = !v2_r || out_ready;
  assign in_ready = !v1_r || adv2;

  always_comb begin
    v1_nxt = v1_r;
    v2_nxt = v2_r;
    if (in_ready) begin
      v1_nxt = in_valid;
    end
    if (adv2) begin
      v2_nxt = v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= roi_res;
    end
    if (adv2 && v1_r) begin
      samp_r <= scaled;
      trim_r <= s1_r.trimmed;
    end
  end

  assign out_valid        = v2_r;
  assign out_sample_out   = samp_r;
  assign out_bits_trimmed = trim_r;

  // accepted item always lands in stage one
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted input did not enter stage one");

  // a stage-one item held behind a stalled output is not dropped
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && !out_ready |=> v1_r && v2_r)
    else $error("stage-one item lost during output stall");

  // no trim flag when ROI handling is off
  a_no_trim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (cfg.roi_shift == '0) && (cfg.bg_shift == '0) |-> !out_bits_trimmed)
    else $error("trim flag set with both shifts zero");

endmodule
